>>> rtl/palindromic_tree_builder_assert.svh
// Assertion macros for the palindromic tree builder.
// Included by rtl/palindromic_tree_builder.sv; needs no other file.
`ifndef PALINDROMIC_TREE_BUILDER_ASSERT_SVH
`define PALINDROMIC_TREE_BUILDER_ASSERT_SVH
`ifndef SYNTH
// Checked while reset is released.
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define PTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/ptb_pkg.sv
// Shared types and constants for the palindromic tree builder.
// No dependencies; imported by rtl/palindromic_tree_builder.sv.
package ptb_pkg;

    localparam int LETTER_W  = 5;
    localparam int LEN_OUT_W = 11;
    localparam int TOTAL_W   = 20;

    localparam int LEN_OUT_MAX = 2047;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_WALK_A = 8'b0000_0010,
        ST_WALK_B = 8'b0000_0100,
        ST_TRD    = 8'b0000_1000,
        ST_TCHK   = 8'b0001_0000,
        ST_LRD    = 8'b0010_0000,
        ST_LCNT   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } t_state;

    // How the extension test of one walk step is decided.
    typedef enum logic [1:0] {
        EXT_CMP   = 2'd0,
        EXT_TRUE  = 2'd1,
        EXT_FALSE = 2'd2
    } t_ext;

endpackage

>>> rtl/palindromic_tree_builder.sv
// Palindromic tree (eertree) builder, top level.
// Depends on rtl/ptb_pkg.sv and rtl/palindromic_tree_builder_assert.svh.
//
// Usage: each input transfer carries one letter (0 for a) and a start flag
// that clears the tree so that this letter opens a new string. Each input
// transfer yields exactly one output transfer: whether a new distinct
// palindrome appeared, the length and number of palindromic suffixes ending
// at the letter, the running count of palindrome occurrences, and an
// overflow flag for a letter dropped because MAX_LEN letters are held.
// Both channels use valid/ready. The block handles one letter at a time.
// The time for a letter grows with the suffix-link steps of both walks and
// depends on whether the palindrome already exists, whether it is a single
// letter, and whether a stale transition entry has to be checked. Each walk
// step in the single node table memory reads a node, then the letter it
// tests. A dropped letter goes straight from the idle state to the finish
// state, where its result is loaded. The block is ready again the cycle
// after a result is loaded. The result sits in an output register, so the
// next letter is taken while it waits; a stalled receiver holds the block
// only when a second result is ready to load.
// Reset clears only control state; no memory sweep is needed, because a
// transition entry counts only if the node it names exists and records
// that very edge as its own.
module palindromic_tree_builder #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ptb_pkg::LETTER_W-1:0]    i_letter,
    input  logic                            i_start_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_is_new_palindrome,
    output logic [ptb_pkg::LEN_OUT_W-1:0]   o_longest_suffix_len,
    output logic [ptb_pkg::LEN_OUT_W-1:0]   o_suffix_palindromes,
    output logic [ptb_pkg::TOTAL_W-1:0]     o_total_palindromes,
    output logic                            o_overflow
);
    import ptb_pkg::*;
    `include "palindromic_tree_builder_assert.svh"

    localparam int NODES  = MAX_LEN + 3;
    localparam int NB     = $clog2(NODES);
    localparam int PB     = $clog2(MAX_LEN + 1);
    localparam int LB     = $clog2(ALPHABET);
    localparam int TDEPTH = NODES * (2 ** LB);

    localparam logic [NB-1:0] ROOT_NEG  = NB'(1);
    localparam logic [NB-1:0] ROOT_ZERO = NB'(2);
    localparam logic [NB-1:0] FIRST_REAL = NB'(3);

    // One entry serves two roles: the letter field is indexed by string
    // position, the remaining fields describe the node of that number.
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [PB-1:0]       len;
        logic [NB-1:0]       link;
        logic [PB-1:0]       cnt;
        logic [NB-1:0]       par;
        logic [LB-1:0]       sym;
    } t_node;

    t_node         node_mem [0:NODES-1];
    logic [NB-1:0] trans_mem [0:TDEPTH-1];

    // Control state.
    t_state        r_state, n_state;
    logic [PB-1:0] r_pos, n_pos;
    logic [NB-1:0] r_last, n_last;
    logic [NB-1:0] r_nodes, n_nodes;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic          r_out_valid, n_out_valid;

    // Working registers of the current letter.
    logic [LETTER_W-1:0] r_c, n_c;
    logic          r_second, n_second;
    t_ext          r_ext, n_ext;
    logic [NB-1:0] r_cur, n_cur;
    logic [NB-1:0] r_nxt, n_nxt;
    logic [PB-1:0] r_clen, n_clen;
    logic          r_cneg, n_cneg;
    logic [NB-1:0] r_par, n_par;
    logic [PB-1:0] r_plen, n_plen;
    logic          r_pneg, n_pneg;
    logic [NB-1:0] r_v, n_v;
    logic [NB-1:0] r_fresh, n_fresh;
    logic          r_drop, n_drop;
    logic          r_ovf, n_ovf;
    logic          r_res_new, n_res_new;
    logic [NB-1:0] r_res_node, n_res_node;
    logic [PB-1:0] r_res_len, n_res_len;
    logic [PB-1:0] r_res_cnt, n_res_cnt;

    // Output register.
    logic                 r_o_new, n_o_new;
    logic [LEN_OUT_W-1:0] r_o_len, n_o_len;
    logic [LEN_OUT_W-1:0] r_o_cnt, n_o_cnt;
    logic [TOTAL_W-1:0]   r_o_total, n_o_total;
    logic                 r_o_ovf, n_o_ovf;

    // Memory ports.
    logic          a_re, b_re, t_re;
    logic [NB-1:0] a_addr, b_addr;
    logic [NB+LB-1:0] t_addr;
    t_node         r_qa, r_qb;
    logic [NB-1:0] r_qt;
    logic          w_node, w_let;
    logic [NB-1:0] w_addr;
    t_node         w_data;
    logic          tw_en;
    logic [NB+LB-1:0] tw_addr;
    logic [NB-1:0] tw_data;

    // Derived values.
    logic [LB-1:0] w_sym;
    logic          is_neg;
    logic [PB-1:0] f_len;
    logic [NB-1:0] f_link;
    logic          found;
    logic [PB-1:0] new_len;
    logic [NB-1:0] fresh_id;
    logic [TOTAL_W:0] sum_total;
    logic          v_in_range;

    assign w_sym    = LB'(r_c);
    assign is_neg   = (r_cur == ROOT_NEG);
    // The roots are not kept in memory; their links and the empty root's length are constants.
    assign f_len    = (r_cur == ROOT_ZERO) ? '0 : r_qa.len;
    assign f_link   = (r_cur == ROOT_NEG || r_cur == ROOT_ZERO) ? ROOT_NEG : r_qa.link;
    assign found    = (r_ext == EXT_TRUE) || (r_ext == EXT_CMP && r_qb.letter == r_c);
    assign new_len  = r_pneg ? PB'(1) : r_plen + PB'(2);
    assign fresh_id = r_nodes + NB'(1);
    assign sum_total = {1'b0, r_total} + (TOTAL_W + 1)'(r_res_cnt);
    assign v_in_range = (r_qt >= FIRST_REAL) && (r_qt <= r_nodes);

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_last = r_last;
        n_nodes = r_nodes;
        n_total = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_c = r_c;
        n_second = r_second;
        n_ext = r_ext;
        n_cur = r_cur;
        n_nxt = r_nxt;
        n_clen = r_clen;
        n_cneg = r_cneg;
        n_par = r_par;
        n_plen = r_plen;
        n_pneg = r_pneg;
        n_v = r_v;
        n_fresh = r_fresh;
        n_drop = r_drop;
        n_ovf = r_ovf;
        n_res_new = r_res_new;
        n_res_node = r_res_node;
        n_res_len = r_res_len;
        n_res_cnt = r_res_cnt;
        n_o_new = r_o_new;
        n_o_len = r_o_len;
        n_o_cnt = r_o_cnt;
        n_o_total = r_o_total;
        n_o_ovf = r_o_ovf;
        a_re = 1'b0;
        a_addr = r_cur;
        b_re = 1'b0;
        b_addr = r_qt;
        t_re = 1'b0;
        t_addr = {r_cur, w_sym};
        w_node = 1'b0;
        w_let = 1'b0;
        w_addr = r_fresh;
        w_data = '{letter: r_c, len: new_len, link: ROOT_ZERO, cnt: PB'(1),
                   par: r_par, sym: w_sym};
        tw_en = 1'b0;
        tw_addr = {r_par, w_sym};
        tw_data = r_fresh;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_c = i_letter;
                    n_second = 1'b0;
                    n_res_new = 1'b0;
                    n_res_len = '0;
                    n_res_cnt = '0;
                    n_drop = 1'b0;
                    n_ovf = 1'b0;
                    n_cur = i_start_req ? ROOT_ZERO : r_last;
                    a_re = 1'b1;
                    a_addr = n_cur;
                    if (i_start_req) begin
                        n_pos = '0;
                        n_last = ROOT_ZERO;
                        n_nodes = ROOT_ZERO;
                        n_total = '0;
                    end
                    if (int'(i_letter) >= ALPHABET) begin
                        n_drop = 1'b1;
                        n_state = ST_FIN;
                    end else if (!i_start_req && int'(r_pos) >= MAX_LEN) begin
                        n_drop = 1'b1;
                        n_ovf = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_WALK_A;
                    end
                end
            end
            ST_WALK_A: begin
                // Test letter at pos-1-len; fetch the suffix link in parallel.
                priority if (is_neg) begin
                    n_ext = EXT_TRUE;
                end else if (f_len >= r_pos) begin
                    n_ext = EXT_FALSE;
                end else begin
                    n_ext = EXT_CMP;
                end
                b_re = 1'b1;
                b_addr = NB'(r_pos - PB'(1) - f_len);
                a_re = 1'b1;
                a_addr = f_link;
                n_nxt = f_link;
                n_clen = f_len;
                n_cneg = is_neg;
                n_state = ST_WALK_B;
            end
            ST_WALK_B: begin
                if (found) begin
                    t_re = 1'b1;
                    t_addr = {r_cur, w_sym};
                    if (r_second) begin
                        n_state = ST_LRD;
                    end else begin
                        n_par = r_cur;
                        n_plen = r_clen;
                        n_pneg = r_cneg;
                        n_state = ST_TRD;
                    end
                end else begin
                    n_cur = r_nxt;
                    n_state = ST_WALK_A;
                end
            end
            ST_TRD, ST_TCHK: begin
                if (r_state == ST_TRD && v_in_range) begin
                    b_re = 1'b1;
                    b_addr = r_qt;
                    n_v = r_qt;
                    n_state = ST_TCHK;
                end else if (r_state == ST_TCHK && r_qb.par == r_par && r_qb.sym == w_sym) begin
                    // The palindrome already exists.
                    n_res_node = r_v;
                    n_res_len = r_qb.len;
                    n_res_cnt = r_qb.cnt;
                    n_state = ST_FIN;
                end else begin
                    n_nodes = fresh_id;
                    n_fresh = fresh_id;
                    n_res_new = 1'b1;
                    if (r_pneg) begin
                        // A single letter links to the empty root.
                        w_node = 1'b1;
                        w_addr = fresh_id;
                        tw_en = 1'b1;
                        tw_data = fresh_id;
                        n_res_node = fresh_id;
                        n_res_len = PB'(1);
                        n_res_cnt = PB'(1);
                        n_state = ST_FIN;
                    end else begin
                        n_second = 1'b1;
                        n_cur = r_nxt;
                        n_state = ST_WALK_A;
                    end
                end
            end
            ST_LRD: begin
                b_re = 1'b1;
                b_addr = r_qt;
                n_v = r_qt;
                n_state = ST_LCNT;
            end
            ST_LCNT: begin
                w_node = 1'b1;
                w_data.link = r_v;
                w_data.cnt = r_qb.cnt + PB'(1);
                tw_en = 1'b1;
                n_res_node = r_fresh;
                n_res_len = new_len;
                n_res_cnt = r_qb.cnt + PB'(1);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_new = r_res_new;
                    n_o_len = (int'(r_res_len) > LEN_OUT_MAX) ? LEN_OUT_W'(LEN_OUT_MAX)
                                                              : LEN_OUT_W'(r_res_len);
                    n_o_cnt = (int'(r_res_cnt) > LEN_OUT_MAX) ? LEN_OUT_W'(LEN_OUT_MAX)
                                                              : LEN_OUT_W'(r_res_cnt);
                    n_o_total = (sum_total > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                                : sum_total[TOTAL_W-1:0];
                    n_o_ovf = r_ovf;
                    if (!r_drop) begin
                        w_let = 1'b1;
                        w_addr = NB'(r_pos);
                        n_pos = r_pos + PB'(1);
                        n_last = r_res_node;
                        n_total = n_o_total;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos <= '0;
            r_last <= ROOT_ZERO;
            r_nodes <= ROOT_ZERO;
            r_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_last <= n_last;
            r_nodes <= n_nodes;
            r_total <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_second <= n_second;
        r_ext <= n_ext;
        r_cur <= n_cur;
        r_nxt <= n_nxt;
        r_clen <= n_clen;
        r_cneg <= n_cneg;
        r_par <= n_par;
        r_plen <= n_plen;
        r_pneg <= n_pneg;
        r_v <= n_v;
        r_fresh <= n_fresh;
        r_drop <= n_drop;
        r_ovf <= n_ovf;
        r_res_new <= n_res_new;
        r_res_node <= n_res_node;
        r_res_len <= n_res_len;
        r_res_cnt <= n_res_cnt;
        r_o_new <= n_o_new;
        r_o_len <= n_o_len;
        r_o_cnt <= n_o_cnt;
        r_o_total <= n_o_total;
        r_o_ovf <= n_o_ovf;
    end

    // Node and letter table: two read ports, one write address per cycle.
    always_ff @(posedge i_clk) begin
        if (w_let) begin
            node_mem[w_addr].letter <= w_data.letter;
        end
        if (w_node) begin
            node_mem[w_addr].len <= w_data.len;
            node_mem[w_addr].link <= w_data.link;
            node_mem[w_addr].cnt <= w_data.cnt;
            node_mem[w_addr].par <= w_data.par;
            node_mem[w_addr].sym <= w_data.sym;
        end
        if (a_re) begin
            r_qa <= node_mem[a_addr];
        end
        if (b_re) begin
            r_qb <= node_mem[b_addr];
        end
    end

    // Transition table.
    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            trans_mem[tw_addr] <= tw_data;
        end
        if (t_re) begin
            r_qt <= trans_mem[t_addr];
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_is_new_palindrome = r_o_new;
    assign o_longest_suffix_len = r_o_len;
    assign o_suffix_palindromes = r_o_cnt;
    assign o_total_palindromes = r_o_total;
    assign o_overflow = r_o_ovf;

    // A new node exists before its letter is counted in the position.
    `PTB_ASSERT(a_node_bound, i_clk, i_rst_n, (r_nodes <= NB'(r_pos) + NB'(3)), "too many nodes")
    `PTB_ASSERT(a_pos_bound, i_clk, i_rst_n, (int'(r_pos) <= MAX_LEN), "string position beyond store")
    `PTB_ASSERT(a_last_bound, i_clk, i_rst_n, (r_last <= r_nodes), "longest suffix names a missing node")
    `PTB_ASSERT(a_res_len, i_clk, i_rst_n, (r_state == ST_FIN && !r_drop) |-> (r_res_len <= r_pos + PB'(1)), "suffix longer than string")

endmodule

>>> sim/palindromic_tree_builder_tb.sv
// Self-checking testbench for the palindromic tree builder.
// Needs rtl/ptb_pkg.sv and rtl/palindromic_tree_builder.sv; a scoreboard class
// rebuilds the eertree letter by letter and checks every output transfer.
`timescale 1ns / 100ps

module palindromic_tree_builder_tb;

    localparam int STR_MAX   = 1024;
    localparam int ABC       = 26;
    localparam int NODE_MAX  = STR_MAX + 3;
    localparam int ROOT_NEG  = 1;
    localparam int ROOT_ZERO = 2;
    localparam int CYCLE_LIMIT = 1500000;

    // One expected output transfer.
    typedef struct {
        logic                          fresh;
        logic [ptb_pkg::LEN_OUT_W-1:0] len;
        logic [ptb_pkg::LEN_OUT_W-1:0] cnt;
        logic [ptb_pkg::TOTAL_W-1:0]   total;
        logic                          ovf;
    } t_pal_result;

    // The scoreboard keeps its own eertree and the queue of results still due.
    class t_pal_scoreboard;
        logic [4:0] letters [STR_MAX];
        int node_len  [NODE_MAX];
        int node_link [NODE_MAX];
        int node_cnt  [NODE_MAX];
        int edge_to   [NODE_MAX*ABC];
        int nodes, tail_node, pos, total;
        int errors;
        t_pal_result due_q[$];

        function new();
            errors = 0;
            foreach (node_cnt[i]) node_cnt[i] = 0;
            foreach (node_len[i]) node_len[i] = 0;
            foreach (node_link[i]) node_link[i] = 0;
            clear_tree();
        endfunction

        function void clear_tree();
            foreach (edge_to[i]) edge_to[i] = 0;
            nodes = 2;
            tail_node = ROOT_ZERO;
            node_len[ROOT_NEG] = -1;
            node_link[ROOT_NEG] = ROOT_NEG;
            node_len[ROOT_ZERO] = 0;
            node_link[ROOT_ZERO] = ROOT_NEG;
            pos = 0;
            total = 0;
        endfunction

        // True when the palindrome at node n can be wrapped by letter c.
        function bit wraps(int n, int c);
            int idx;
            idx = pos - 1 - node_len[n];
            if (idx < 0) return 0;
            if (idx >= pos) return 1;
            return letters[idx] == c;
        endfunction

        function void note_letter(logic [4:0] c, logic start);
            t_pal_result r;
            int cur, nxt, fn, len_v, cnt_v;
            if (start) clear_tree();
            r.fresh = 1'b0;
            r.len = '0;
            r.cnt = '0;
            if (c >= ABC || pos >= STR_MAX) begin
                r.total = total[ptb_pkg::TOTAL_W-1:0];
                r.ovf = (c >= ABC) ? 1'b0 : 1'b1;
                due_q = {due_q, r};
                return;
            end
            cur = tail_node;
            while (!wraps(cur, c)) cur = node_link[cur];
            nxt = edge_to[cur*ABC + c];
            if (nxt != 0) begin
                tail_node = nxt;
            end else begin
                fn = nodes + 1;
                nodes = fn;
                tail_node = fn;
                node_len[fn] = node_len[cur] + 2;
                edge_to[cur*ABC + c] = fn;
                if (node_len[fn] == 1) begin
                    node_link[fn] = ROOT_ZERO;
                    node_cnt[fn] = 1;
                end else begin
                    do cur = node_link[cur]; while (!wraps(cur, c));
                    node_link[fn] = edge_to[cur*ABC + c];
                    node_cnt[fn] = 1 + node_cnt[node_link[fn]];
                end
                r.fresh = 1'b1;
            end
            letters[pos] = c;
            pos++;
            total = (total + node_cnt[tail_node] > 20'hFFFFF) ? 20'hFFFFF
                                                             : total + node_cnt[tail_node];
            len_v = (node_len[tail_node] > 2047) ? 2047 : node_len[tail_node];
            cnt_v = (node_cnt[tail_node] > 2047) ? 2047 : node_cnt[tail_node];
            r.len = len_v[ptb_pkg::LEN_OUT_W-1:0];
            r.cnt = cnt_v[ptb_pkg::LEN_OUT_W-1:0];
            r.total = total[ptb_pkg::TOTAL_W-1:0];
            r.ovf = 1'b0;
            due_q = {due_q, r};
        endfunction

        function void check_result(t_pal_result got);
            t_pal_result w;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected output transfer, actual %0d/%0d/%0d/%0d/%0d",
                         $time, got.fresh, got.len, got.cnt, got.total, got.ovf);
                errors++;
                return;
            end
            w = due_q.pop_front();
            if (got.fresh !== w.fresh) begin
                $display("%0t: is_new_palindrome expected %0d actual %0d",
                         $time, w.fresh, got.fresh);
                errors++;
            end
            if (got.len !== w.len) begin
                $display("%0t: longest_suffix_len expected %0d actual %0d",
                         $time, w.len, got.len);
                errors++;
            end
            if (got.cnt !== w.cnt) begin
                $display("%0t: suffix_palindromes expected %0d actual %0d",
                         $time, w.cnt, got.cnt);
                errors++;
            end
            if (got.total !== w.total) begin
                $display("%0t: total_palindromes expected %0d actual %0d",
                         $time, w.total, got.total);
                errors++;
            end
            if (got.ovf !== w.ovf) begin
                $display("%0t: overflow expected %0d actual %0d", $time, w.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [ptb_pkg::LETTER_W-1:0]  i_letter;
    logic                          i_start_req;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_is_new_palindrome;
    logic [ptb_pkg::LEN_OUT_W-1:0] o_longest_suffix_len;
    logic [ptb_pkg::LEN_OUT_W-1:0] o_suffix_palindromes;
    logic [ptb_pkg::TOTAL_W-1:0]   o_total_palindromes;
    logic                          o_overflow;

    palindromic_tree_builder u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_letter             (i_letter),
        .i_start_req          (i_start_req),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_is_new_palindrome  (o_is_new_palindrome),
        .o_longest_suffix_len (o_longest_suffix_len),
        .o_suffix_palindromes (o_suffix_palindromes),
        .o_total_palindromes  (o_total_palindromes),
        .o_overflow           (o_overflow)
    );

    t_pal_scoreboard sb = new();

    // Set near the end of the run: from then on neither side idles.
    bit quiet_mode = 0;
    int letters_sent = 0;
    int cycle_count = 0;

    // 2 ns clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung block must not keep the run alive forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL palindromic_tree_builder");
            $finish;
        end
    end

    // Receiver side. Outputs are sampled at the edge, before the block's own
    // updates land, so a transfer seen here is exactly the one the edge took.
    // The ready line idles in short random bursts, and once it holds off for
    // a long stretch so that the block backs up and stops taking letters.
    int  stall_left = 0;
    bit  long_hold_done = 0;
    t_pal_result seen;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.fresh = o_is_new_palindrome;
                seen.len   = o_longest_suffix_len;
                seen.cnt   = o_suffix_palindromes;
                seen.total = o_total_palindromes;
                seen.ovf   = o_overflow;
                sb.check_result(seen);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && !long_hold_done && letters_sent >= 300) begin
                long_hold_done = 1;
                stall_left = 400;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end else begin
            i_out_ready <= 1'b0;
        end
    end

    // Offers one letter and waits for its input transfer. Valid stays high
    // after the transfer; an idle burst before the next letter drops it.
    task automatic send_letter(input logic [4:0] c, input logic start);
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_letter    <= c;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_letter(c, start);
        letters_sent++;
    endtask

    // A whole string: start flag on the first letter, letters drawn from the
    // first span letters of the alphabet so that palindromes are common.
    task automatic send_string(input int n, input int span, input bit noisy);
        logic [4:0] c;
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) c = 5'($urandom_range(ABC, 31));
            else c = 5'($urandom_range(0, span - 1));
            send_letter(c, k == 0);
        end
    endtask

    initial begin
        int wait_cycles;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_letter    <= '0;
        i_start_req <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first letter without a start flag, runs of one letter,
        // nested palindromes, the highest letter, letters outside the
        // alphabet alone and together with a start request.
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd25, 1'b1);
        send_letter(5'd25, 1'b0);
        send_letter(5'd12, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd30, 1'b1);
        send_letter(5'd7, 1'b0);
        send_letter(5'd7, 1'b1);
        send_letter(5'd3, 1'b0);
        send_letter(5'd7, 1'b0);
        send_letter(5'd21, 1'b0);

        // Random strings, mostly clean, some with dropped letters mixed in.
        while (letters_sent < 350)
            send_string($urandom_range(1, 40), $urandom_range(1, ABC),
                        $urandom_range(0, 4) == 0);

        // One string that fills the letter store and runs past it.
        send_string(STR_MAX + 12, $urandom_range(1, 3), 1'b0);

        while (letters_sent < 1440)
            send_string($urandom_range(1, 40), $urandom_range(1, ABC),
                        $urandom_range(0, 4) == 0);

        // Last stretch at full rate on both sides.
        quiet_mode = 1;
        while (letters_sent < 1500)
            send_string($urandom_range(1, 30), $urandom_range(1, 4), 1'b0);
        i_in_valid <= 1'b0;

        while (sb.due_q.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 100) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("PASS palindromic_tree_builder");
        end else begin
            $display("FAIL palindromic_tree_builder");
        end
        $finish;
    end

endmodule
